// ===== rtl/dorl_pkg.sv =====
// dorl_pkg: shared widths, register indexes and reset values for the
// dram open-row latency block. No dependencies.

package dorl_pkg;

  // table geometry
  localparam int BANKS       = 16;
  localparam int BANK_W      = $clog2(BANKS);

  // field widths
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 16;
  localparam int LAT_W       = 32;
  localparam int ROW_W       = 32;
  localparam int CHUNK_W     = 16;

  // configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;

  // register widths
  localparam int COL_BITS_W  = 5;
  localparam int BANK_BITS_W = 3;
  localparam int BLEN_W      = 9;
  localparam int TICK_W      = 16;
  localparam int PEN_W       = 18;

  // clamps on the address split
  localparam logic [COL_BITS_W-1:0]  MAX_COL_BITS  = 5'd16;
  localparam logic [BANK_BITS_W-1:0] MAX_BANK_BITS = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COL_BITS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_BITS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAS_LATENCY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_PENALTY = 3'd5;

  // reset values
  localparam logic [COL_BITS_W-1:0]  COL_BITS_RST     = 5'd10;
  localparam logic [BANK_BITS_W-1:0] BANK_BITS_RST    = 3'd3;
  localparam logic [BLEN_W-1:0]      BURST_LENGTH_RST = 9'd64;
  localparam logic [TICK_W-1:0]      CAS_LATENCY_RST  = 16'd14;
  localparam logic [TICK_W-1:0]      BURST_TIME_RST   = 16'd4;
  localparam logic [PEN_W-1:0]       MISS_PENALTY_RST = 18'd64;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LAT_W-1:0]   lat_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [BANK_W-1:0]  bank_t;

endpackage

// ===== rtl/dorl_if.sv =====
// dorl_if: valid/ready channels for requests and latency results.
// Depends on dorl_pkg for the payload types.

interface dorl_req_if;
  import dorl_pkg::*;
  logic   valid;
  logic   ready;
  addr_t  byte_address;
  count_t byte_count;

  modport source (output valid, output byte_address, output byte_count, input ready);
  modport sink   (input valid, input byte_address, input byte_count, output ready);
endinterface

interface dorl_rsp_if;
  import dorl_pkg::*;
  logic valid;
  logic ready;
  lat_t latency_ticks;

  modport source (output valid, output latency_ticks, input ready);
  modport sink   (input valid, input latency_ticks, output ready);
endinterface

// ===== rtl/dram_open_row_latency.sv =====
// dram_open_row_latency: top level, request splitter, burst divider and
// open-row table. Depends on dorl_pkg and the channels in dorl_if.
//
// Usage:
//   req carries byte_address and byte_count; one transfer on req gives
//   exactly one transfer on rsp with latency_ticks, in request order.
//   The cfg port (cfg_we, cfg_index, cfg_data) writes the six timing and
//   geometry registers; write only while no request is in flight.
//   A request is cut into chunks that stay inside one row. Each chunk
//   is first split and its open-row table entry read; the burst count
//   then comes from the burst-count divider at one quotient bit per
//   cycle, is multiplied by the burst time, and last the chunk's latency
//   is accumulated and the table written back. rsp.valid rises at the
//   same edge as req.ready goes high again, also for a zero-size request;
//   a new request is taken only once the previous one is finished.
//   The result sits in an output register, so req.ready returns as soon
//   as the result is loaded, even while rsp is stalled; a second finished
//   result waits inside until the register is taken.
//   Reset restores the register defaults and marks every bank's open row
//   as row zero through per-bank valid bits; no clearing pass is needed.

module dram_open_row_latency import dorl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dorl_req_if.sink              req,
  dorl_rsp_if.source            rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHUNK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int DIV_STEPS = CHUNK_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int SHIFT_W   = 6;
  localparam int ROOM_W    = CHUNK_W + 1;
  localparam int BURSTS_W  = CHUNK_W + 1;
  localparam int PROD_W    = BURSTS_W + TICK_W;
  localparam int SUM_W     = PROD_W + 2;

  // configuration registers
  logic [COL_BITS_W-1:0]  col_bits;
  logic [BANK_BITS_W-1:0] bank_bits;
  logic [BLEN_W-1:0]      burst_length;
  logic [TICK_W-1:0]      cas_latency;
  logic [TICK_W-1:0]      burst_time;
  logic [PEN_W-1:0]       miss_penalty;

  // control and datapath registers
  logic [2:0]          state;
  addr_t               base;
  count_t              size;
  count_t              offset;
  lat_t                total;
  logic [CHUNK_W-1:0]  chunk;
  bank_t               bank;
  row_t                row;
  logic [CHUNK_W-1:0]  dq;
  logic [BLEN_W-1:0]   rem;
  logic [STEP_W-1:0]   step;
  logic [PROD_W-1:0]   prod;
  logic                out_valid;
  lat_t                out_data;

  // open-row table: memory plus per-bank valid bits
  row_t                row_mem [BANKS];
  row_t                rdata;
  logic [BANKS-1:0]    row_valid;

  // combinational signals
  logic [COL_BITS_W-1:0]  cb;
  logic [BANK_BITS_W-1:0] bb;
  logic [BLEN_W-1:0]      blen;
  addr_t                  cur_addr;
  logic [ROOM_W-1:0]      row_size;
  logic [ROOM_W-1:0]      col;
  logic [ROOM_W-1:0]      room;
  count_t                 remain;
  logic [CHUNK_W-1:0]     chunk_c;
  bank_t                  bank_mask;
  bank_t                  bank_c;
  row_t                   row_c;
  logic [BLEN_W:0]        rem_sh;
  logic                   div_ge;
  logic [BLEN_W-1:0]      rem_n;
  logic [BURSTS_W-1:0]    bursts;
  logic [PROD_W-1:0]      prod_c;
  row_t                   open_row;
  logic                   miss;
  logic [SUM_W-1:0]       sum;
  lat_t                   total_sat;
  count_t                 offset_n;
  logic                   out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      col_bits     <= COL_BITS_RST;
      bank_bits    <= BANK_BITS_RST;
      burst_length <= BURST_LENGTH_RST;
      cas_latency  <= CAS_LATENCY_RST;
      burst_time   <= BURST_TIME_RST;
      miss_penalty <= MISS_PENALTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COL_BITS:     col_bits     <= cfg_data[COL_BITS_W-1:0];
        REG_BANK_BITS:    bank_bits    <= cfg_data[BANK_BITS_W-1:0];
        REG_BURST_LENGTH: burst_length <= cfg_data[BLEN_W-1:0];
        REG_CAS_LATENCY:  cas_latency  <= cfg_data[TICK_W-1:0];
        REG_BURST_TIME:   burst_time   <= cfg_data[TICK_W-1:0];
        REG_MISS_PENALTY: miss_penalty <= cfg_data[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  assign cb   = (col_bits > MAX_COL_BITS) ? MAX_COL_BITS : col_bits;
  assign bb   = (bank_bits > MAX_BANK_BITS) ? MAX_BANK_BITS : bank_bits;
  assign blen = (burst_length == '0) ? BLEN_W'(1) : burst_length;

  // chunk split: column, room left in the row, bank and row of this chunk
  assign cur_addr  = base + ADDR_W'(offset);
  assign row_size  = ROOM_W'(1) << cb;
  assign col       = cur_addr[ROOM_W-1:0] & (row_size - ROOM_W'(1));
  assign room      = row_size - col;
  assign remain    = size - offset;
  assign chunk_c   = (ROOM_W'(remain) > room) ? room[CHUNK_W-1:0] : remain;
  assign bank_mask = BANK_W'((5'd1 << bb) - 5'd1);
  assign bank_c    = BANK_W'(cur_addr >> cb) & bank_mask;
  assign row_c     = ROW_W'(cur_addr >> (SHIFT_W'(cb) + SHIFT_W'(bb)));

  // restoring divider step, one quotient bit per cycle
  assign rem_sh = {rem, dq[CHUNK_W-1]};
  assign div_ge = rem_sh >= {1'b0, blen};
  assign rem_n  = div_ge ? BLEN_W'(rem_sh - {1'b0, blen}) : rem_sh[BLEN_W-1:0];

  // ceiling of the quotient, then burst time
  assign bursts = BURSTS_W'(dq) + BURSTS_W'(rem != '0);
  assign prod_c = bursts * burst_time;

  // hit check and saturating accumulate
  assign open_row  = row_valid[bank] ? rdata : '0;
  assign miss      = open_row != row;
  assign sum       = SUM_W'(total) + SUM_W'(cas_latency) + SUM_W'(prod)
                   + (miss ? SUM_W'(miss_penalty) : SUM_W'(0));
  assign total_sat = (sum > SUM_W'({LAT_W{1'b1}})) ? {LAT_W{1'b1}} : sum[LAT_W-1:0];
  assign offset_n  = offset + chunk;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= (req.byte_count == '0) ? S_DONE : S_CHUNK;
          end
        end
        S_CHUNK: state <= S_DIV;
        S_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: state <= (offset_n == size) ? S_DONE : S_CHUNK;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        base   <= req.byte_address;
        size   <= req.byte_count;
        offset <= '0;
        total  <= '0;
      end
      S_CHUNK: begin
        chunk <= chunk_c;
        bank  <= bank_c;
        row   <= row_c;
        dq    <= chunk_c;
        rem   <= '0;
        step  <= '0;
      end
      S_DIV: begin
        dq   <= {dq[CHUNK_W-2:0], div_ge};
        rem  <= rem_n;
        step <= step + STEP_W'(1);
      end
      S_MUL: prod <= prod_c;
      S_ACC: begin
        total  <= total_sat;
        offset <= offset_n;
      end
      default: ;
    endcase
  end

  // open-row memory: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (state == S_ACC && miss) begin
      row_mem[bank] <= row;
    end
    if (state == S_CHUNK) begin
      rdata <= row_mem[bank_c];
    end
  end

  // valid bits stand for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (state == S_ACC && miss) begin
      row_valid[bank] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= total;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.latency_ticks = out_data;

endmodule

// ===== rtl/dorl_checker.sv =====
// dorl_checker: port-level checks on dram_open_row_latency, attached by bind.
// Depends on dorl_pkg for the payload widths.

module dorl_checker import dorl_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input lat_t out_data
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // one request at a time: busy after each accepted transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // a new result is loaded only at the end of a request's work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in flight");

endmodule

bind dram_open_row_latency dorl_checker u_dorl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_data  (rsp.latency_ticks)
);
